FILE: rtl/iba_pkg.sv
// Shared types and codes for the integer binary operation unit.
package iba_pkg;

   // Operation codes carried by a request
   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_SUB     = 3'd1,
      OP_MUL     = 3'd2,
      OP_DIV     = 3'd3,
      OP_POW     = 3'd4,
      OP_LESS    = 3'd5,
      OP_GREATER = 3'd6,
      OP_EQUAL   = 3'd7
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_DIV_ZERO = 2'd1,
      STS_NEG_EXP  = 2'd2
   } status_type;

   // Sequencer states of the engine
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALU,
      ST_DIV_ABS_A,
      ST_DIV_ABS_B,
      ST_DIV_STEP,
      ST_DIV_SIGN,
      ST_POW_CHECK,
      ST_MUL_STEP,
      ST_DONE
   } state_type;

   // Where a finished multiply goes
   typedef enum logic [1:0] {
      MD_RESULT,
      MD_ACC,
      MD_BASE
   } mul_dest_type;

   // Control from the top level to the engine
   typedef struct packed {
      logic   start;
      logic   take;
      op_type op;
   } eng_ctrl_type;

   // Status from the engine to the top level
   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

endpackage

FILE: rtl/integer_binary_op_unit.sv
// Integer binary operation unit: add, sub, mul, div, power and signed compares.
// Zero divisors and negative exponents skip the datapath and return an error status; a
// power runs bit length + set bits - 1 multiplies for a nonzero exponent, none for zero.
// One request at a time: a new one is taken only once the engine is idle again, after its
// last result has moved to the response register.
// Synchronous active-high reset returns the sequencer to idle and drops rsp_valid.
module integer_binary_op_unit import iba_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_kind,
   input  logic signed [DATA_WIDTH-1:0] req_left_operand,
   input  logic signed [DATA_WIDTH-1:0] req_right_operand,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic [1:0]                   rsp_status
);

   eng_ctrl_type          eng_ctrl;
   eng_stat_type          eng_stat;
   logic [DATA_WIDTH-1:0] eng_result;
   status_type            eng_status;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   status_type            rsp_status_ff, rsp_status_in;

   iba_engine #(.DATA_WIDTH(DATA_WIDTH)) u_engine (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (eng_ctrl),
      .left_operand  (req_left_operand),
      .right_operand (req_right_operand),
      .stat          (eng_stat),
      .result_value  (eng_result),
      .status        (eng_status)
   );

   // start the engine on a request, drain it when the output slot frees
   assign req_ready     = eng_stat.idle;
   assign eng_ctrl.start = req_valid & eng_stat.idle;
   assign eng_ctrl.op    = op_type'(req_kind);
   assign eng_ctrl.take  = eng_stat.done & (~rsp_valid_ff | rsp_ready);

   // load or drop the response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (eng_ctrl.take) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = eng_result;
         rsp_status_in = eng_status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = $signed(rsp_value_ff);
   assign rsp_status       = rsp_status_ff;

   // an error response always carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STS_OK) |-> (rsp_result_value == '0))
      else $error("error response with nonzero value");

   // the engine is never idle and done at once
   assert property (@(posedge clock) disable iff (reset)
      !(eng_stat.idle && eng_stat.done))
      else $error("engine idle and done together");

   // an accepted request leaves the engine busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !eng_stat.idle)
      else $error("engine stayed idle after a request");

endmodule

FILE: rtl/iba_addsub.sv
// Shared add/subtract unit with carry out, used for every arithmetic step.
module iba_addsub import iba_pkg::*; #(
   parameter int WIDTH = 33
) (
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic             sub,
   output logic [WIDTH-1:0] sum,
   output logic             carry
);

   logic [WIDTH-1:0] y_eff;
   logic [WIDTH:0]   total;

   // invert the second operand and inject a carry to subtract
   assign y_eff = sub ? ~y : y;
   assign total = {1'b0, x} + {1'b0, y_eff} + {{WIDTH{1'b0}}, sub};
   assign sum   = total[WIDTH-1:0];
   assign carry = total[WIDTH];

endmodule

FILE: rtl/iba_engine.sv
// Sequencer and datapath that run every operation through one shared adder.
module iba_engine import iba_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  eng_ctrl_type          ctrl,
   input  logic [DATA_WIDTH-1:0] left_operand,
   input  logic [DATA_WIDTH-1:0] right_operand,
   output eng_stat_type          stat,
   output logic [DATA_WIDTH-1:0] result_value,
   output status_type            status
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(DATA_WIDTH);
   localparam logic [CW-1:0] LAST_BIT = CW'(DATA_WIDTH - 1);

   state_type    state_ff, state_in;
   op_type       op_ff, op_in;
   mul_dest_type dest_ff, dest_in;
   status_type   st_ff, st_in;
   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic         neg_ff, neg_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] exp_ff, exp_in;
   logic [W-1:0] md_ff, md_in;
   logic [W-1:0] mr_ff, mr_in;
   logic [W-1:0] prod_ff, prod_in;
   logic [W-1:0] res_ff, res_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [W:0]   add_x, add_y, add_sum;
   logic         add_sub, add_carry;
   logic [W:0]   rem_shift;

   iba_addsub #(.WIDTH(W + 1)) u_addsub (
      .x     (add_x),
      .y     (add_y),
      .sub   (add_sub),
      .sum   (add_sum),
      .carry (add_carry)
   );

   assign rem_shift    = {rem_ff, quo_ff[W-1]};
   assign stat.idle    = (state_ff == ST_IDLE);
   assign stat.done    = (state_ff == ST_DONE);
   assign result_value = res_ff;
   assign status       = st_ff;

   // hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the datapath registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      dest_ff <= dest_in;
      st_ff   <= st_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
      exp_ff  <= exp_in;
      md_ff   <= md_in;
      mr_ff   <= mr_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      cnt_ff  <= cnt_in;
   end

   // advance the sequencer and steer the shared adder
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      dest_in  = dest_ff;
      st_in    = st_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      exp_in   = exp_ff;
      md_in    = md_ff;
      mr_in    = mr_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      add_x    = '0;
      add_y    = '0;
      add_sub  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               op_in = ctrl.op;
               a_in  = left_operand;
               b_in  = right_operand;
               st_in = STS_OK;
               case (ctrl.op)
                  OP_MUL: begin
                     md_in    = left_operand;
                     mr_in    = right_operand;
                     prod_in  = '0;
                     cnt_in   = LAST_BIT;
                     dest_in  = MD_RESULT;
                     state_in = ST_MUL_STEP;
                  end
                  OP_DIV: begin
                     if (right_operand == '0) begin
                        res_in   = '0;
                        st_in    = STS_DIV_ZERO;
                        state_in = ST_DONE;
                     end else begin
                        neg_in   = left_operand[W-1] ^ right_operand[W-1];
                        state_in = ST_DIV_ABS_A;
                     end
                  end
                  OP_POW: begin
                     if (right_operand[W-1]) begin
                        res_in   = '0;
                        st_in    = STS_NEG_EXP;
                        state_in = ST_DONE;
                     end else begin
                        acc_in   = {{(W-1){1'b0}}, 1'b1};
                        base_in  = left_operand;
                        exp_in   = right_operand;
                        state_in = ST_POW_CHECK;
                     end
                  end
                  default: begin
                     state_in = ST_ALU;
                  end
               endcase
            end
         end

         // single pass: add, subtract and the signed compares
         ST_ALU: begin
            add_sub = (op_ff != OP_ADD);
            if (op_ff == OP_GREATER) begin
               add_x = {b_ff[W-1], b_ff};
               add_y = {a_ff[W-1], a_ff};
            end else begin
               add_x = {a_ff[W-1], a_ff};
               add_y = {b_ff[W-1], b_ff};
            end
            case (op_ff)
               OP_ADD, OP_SUB: res_in = add_sum[W-1:0];
               OP_EQUAL:       res_in = {{(W-1){1'b0}}, (add_sum == '0)};
               default:        res_in = {{(W-1){1'b0}}, add_sum[W]};
            endcase
            state_in = ST_DONE;
         end

         // take magnitudes of dividend and divisor
         ST_DIV_ABS_A: begin
            add_sub  = 1'b1;
            add_y    = {a_ff[W-1], a_ff};
            quo_in   = a_ff[W-1] ? add_sum[W-1:0] : a_ff;
            state_in = ST_DIV_ABS_B;
         end

         ST_DIV_ABS_B: begin
            add_sub  = 1'b1;
            add_y    = {b_ff[W-1], b_ff};
            b_in     = b_ff[W-1] ? add_sum[W-1:0] : b_ff;
            rem_in   = '0;
            cnt_in   = LAST_BIT;
            state_in = ST_DIV_STEP;
         end

         // one restoring quotient bit per cycle
         ST_DIV_STEP: begin
            add_sub = 1'b1;
            add_x   = rem_shift;
            add_y   = {1'b0, b_ff};
            rem_in  = add_carry ? add_sum[W-1:0] : rem_shift[W-1:0];
            quo_in  = {quo_ff[W-2:0], add_carry};
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DIV_SIGN;
            end
         end

         // apply the quotient sign
         ST_DIV_SIGN: begin
            add_sub  = 1'b1;
            add_y    = {1'b0, quo_ff};
            res_in   = neg_ff ? add_sum[W-1:0] : quo_ff;
            state_in = ST_DONE;
         end

         // pick the next square-and-multiply step, or finish when the exponent is zero
         ST_POW_CHECK: begin
            prod_in  = '0;
            cnt_in   = LAST_BIT;
            state_in = ST_MUL_STEP;
            if (exp_ff == '0) begin
               res_in   = acc_ff;
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               md_in   = acc_ff;
               mr_in   = base_ff;
               dest_in = MD_ACC;
            end else begin
               md_in   = base_ff;
               mr_in   = base_ff;
               dest_in = MD_BASE;
            end
         end

         // one multiplier bit per cycle, most significant first
         ST_MUL_STEP: begin
            add_x   = {1'b0, prod_ff[W-2:0], 1'b0};
            add_y   = mr_ff[W-1] ? {1'b0, md_ff} : '0;
            prod_in = add_sum[W-1:0];
            mr_in   = {mr_ff[W-2:0], 1'b0};
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               case (dest_ff)
                  MD_ACC: begin
                     acc_in = add_sum[W-1:0];
                     if (exp_ff[W-1:1] == '0) begin
                        res_in   = add_sum[W-1:0];
                        state_in = ST_DONE;
                     end else begin
                        md_in   = base_ff;
                        mr_in   = base_ff;
                        prod_in = '0;
                        cnt_in  = LAST_BIT;
                        dest_in = MD_BASE;
                     end
                  end
                  MD_BASE: begin
                     base_in  = add_sum[W-1:0];
                     exp_in   = {1'b0, exp_ff[W-1:1]};
                     state_in = ST_POW_CHECK;
                  end
                  default: begin
                     res_in   = add_sum[W-1:0];
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // hold the result until the output register takes it
         ST_DONE: begin
            if (ctrl.take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: dv/tb_top.sv
// Testbench for integer_binary_op_unit with a predictor and a request/response scoreboard.
`timescale 1ns / 100ps

module tb_top;
   import iba_pkg::*;

   localparam int W = 32;
   localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MINUS_ONE = '1;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 1100;

   typedef struct {
      op_type         op;
      logic [W-1:0]   lhs;
      logic [W-1:0]   rhs;
      logic [W-1:0]   value;
      status_type     status;
   } alu_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [2:0]          req_kind = '0;
   logic signed [W-1:0] req_left_operand = '0;
   logic signed [W-1:0] req_right_operand = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_result_value;
   logic [1:0]          rsp_status;

   alu_result_type alu_results_due[$];
   int          mismatch_count = 0;
   int          rsp_hold_cycles = 0;
   int          send_run_left = 0;
   bit          send_steady = 1'b0;
   int          recv_run_left = 0;
   bit          recv_steady = 1'b0;

   integer_binary_op_unit #(.DATA_WIDTH(W)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_left_operand  (req_left_operand),
      .req_right_operand (req_right_operand),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status)
   );

   always #6 clock = ~clock;

   // Compute the expected value and status of one request
   function automatic alu_result_type evaluate_op(op_type op, logic [W-1:0] lhs,
                                                  logic [W-1:0] rhs);
      alu_result_type r;
      logic [W-1:0] mag_l;
      logic [W-1:0] mag_r;
      logic [W-1:0] quot;
      logic [W-1:0] acc;
      logic [W-1:0] base;
      logic [W-1:0] expo;
      r.op = op;
      r.lhs = lhs;
      r.rhs = rhs;
      r.value = '0;
      r.status = STS_OK;
      case (op)
         OP_ADD: r.value = lhs + rhs;
         OP_SUB: r.value = lhs - rhs;
         OP_MUL: r.value = lhs * rhs;
         OP_DIV: begin
            if (rhs == '0) begin
               r.status = STS_DIV_ZERO;
            end else begin
               // divide magnitudes, then truncate toward zero by fixing the sign
               mag_l = lhs[W-1] ? -lhs : lhs;
               mag_r = rhs[W-1] ? -rhs : rhs;
               quot = mag_l / mag_r;
               r.value = (lhs[W-1] ^ rhs[W-1]) ? -quot : quot;
            end
         end
         OP_POW: begin
            if (rhs[W-1]) begin
               r.status = STS_NEG_EXP;
            end else begin
               // square and multiply, wrapping at every product
               acc = 1;
               base = lhs;
               expo = rhs;
               while (expo != '0) begin
                  if (expo[0]) acc = acc * base;
                  base = base * base;
                  expo = expo >> 1;
               end
               r.value = acc;
            end
         end
         OP_LESS:    r.value = W'($signed(lhs) < $signed(rhs));
         OP_GREATER: r.value = W'($signed(lhs) > $signed(rhs));
         default:    r.value = W'(lhs == rhs);
      endcase
      return r;
   endfunction

   // Operands weighted toward small values and the extremes
   function automatic logic [W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $urandom_range(0, 32) - 16;
         6: begin
            case ($urandom_range(0, 4))
               0:       return '0;
               1:       return 1;
               2:       return MINUS_ONE;
               3:       return MAX_POS;
               default: return MIN_NEG;
            endcase
         end
         7:       return $urandom >> $urandom_range(1, W - 1);
         8:       return -($urandom >> $urandom_range(1, W - 1));
         default: return $urandom | MIN_NEG;
      endcase
   endfunction

   // Keep exponents mostly short so power stays quick, with a few long and negative ones
   function automatic logic [W-1:0] pick_exponent();
      int r;
      r = $urandom_range(0, 39);
      if (r < 3) return $urandom | MIN_NEG;
      if (r == 3) return $urandom & MAX_POS;
      return $urandom_range(0, 40);
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endtask

   // Offer one request, hold it until accepted, then queue its expected result
   task automatic send_request(input op_type op, input logic [W-1:0] lhs,
                               input logic [W-1:0] rhs, input bit paced = 1'b1);
      int gap;
      if (send_run_left == 0) begin
         send_run_left = $urandom_range(1, 40);
         send_steady = ($urandom_range(0, 2) == 0);
      end
      send_run_left--;
      gap = (!paced || send_steady) ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= op;
      req_left_operand <= lhs;
      req_right_operand <= rhs;
      do @(posedge clock); while (req_ready !== 1'b1);
      alu_results_due.push_back(evaluate_op(op, lhs, rhs));
   endtask

   task automatic test_arith_extremes();
      send_request(OP_ADD, MAX_POS, 1);
      send_request(OP_ADD, MIN_NEG, MIN_NEG);
      send_request(OP_SUB, MIN_NEG, 1);
      send_request(OP_SUB, '0, MIN_NEG);
      send_request(OP_MUL, MAX_POS, MAX_POS);
      send_request(OP_MUL, MIN_NEG, MINUS_ONE);
   endtask

   task automatic test_divide_cases();
      send_request(OP_DIV, 5, '0);
      send_request(OP_DIV, MIN_NEG, '0);
      send_request(OP_DIV, MIN_NEG, MINUS_ONE);
      send_request(OP_DIV, -7, 2);
      send_request(OP_DIV, 7, -2);
      send_request(OP_DIV, -7, -2);
      send_request(OP_DIV, MAX_POS, MIN_NEG);
   endtask

   task automatic test_power_cases();
      send_request(OP_POW, '0, '0);
      send_request(OP_POW, MIN_NEG, '0);
      send_request(OP_POW, 3, MINUS_ONE);
      send_request(OP_POW, 2, W - 1);
      send_request(OP_POW, MINUS_ONE, MAX_POS);
      send_request(OP_POW, 3, MAX_POS);
   endtask

   task automatic test_compares();
      send_request(OP_LESS, MIN_NEG, MAX_POS);
      send_request(OP_LESS, MAX_POS, MIN_NEG);
      send_request(OP_GREATER, MINUS_ONE, MINUS_ONE);
      send_request(OP_GREATER, MAX_POS, MIN_NEG);
      send_request(OP_EQUAL, MIN_NEG, MIN_NEG);
      send_request(OP_EQUAL, '0, MINUS_ONE);
   endtask

   task automatic test_random_mix(input int count);
      op_type       op;
      logic [W-1:0] lhs;
      logic [W-1:0] rhs;
      repeat (count) begin
         op = op_type'($urandom_range(0, 7));
         lhs = pick_operand();
         case (op)
            OP_DIV:  rhs = ($urandom_range(0, 7) == 0) ? '0 : pick_operand();
            OP_POW:  rhs = pick_exponent();
            default: rhs = ($urandom_range(0, 3) == 0) ? lhs : pick_operand();
         endcase
         send_request(op, lhs, rhs);
      end
   endtask

   // Stall the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      rsp_hold_cycles = 400;
      repeat (12) begin
         send_request(op_type'($urandom_range(0, 1) ? OP_ADD : OP_LESS),
                      pick_operand(), pick_operand(), 1'b0);
      end
   endtask

   // Response side: before each response, stall for the hold a test asks for, else a random number of cycles
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            if (recv_run_left == 0) begin
               recv_run_left = $urandom_range(1, 40);
               recv_steady = ($urandom_range(0, 2) == 0);
            end
            recv_run_left--;
            stall = recv_steady ? 0 : $urandom_range(0, 19);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Compare each accepted response with the oldest expected result
   always @(posedge clock) begin : check_response
      alu_result_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (alu_results_due.size() == 0) begin
            note_failure($sformatf("response with no request: value %0d status %0d",
                                   rsp_result_value, rsp_status));
         end else begin
            due = alu_results_due.pop_front();
            if (rsp_result_value !== due.value || rsp_status !== due.status) begin
               note_failure($sformatf("%s %0d, %0d: expected %0d/%s, got %0d/%0d",
                                      due.op.name(), $signed(due.lhs), $signed(due.rhs),
                                      $signed(due.value), due.status.name(),
                                      rsp_result_value, rsp_status));
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_arith_extremes();
      test_divide_cases();
      test_power_cases();
      test_compares();
      test_random_mix(350);
      test_backpressure();
      test_random_mix(350);

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then allow time for any stray response
      while (alu_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #40ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
